// ===== src/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// types, codes and reset values shared by the circuit breaker table unit
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

   localparam int NUM_BREAKERS_DEF = 16;

   // item opcodes
   typedef enum logic [1:0] {
      OP_CHECK   = 2'd0,
      OP_SUCCESS = 2'd1,
      OP_FAILURE = 2'd2,
      OP_RESET   = 2'd3
   } op_type;

   // breaker states
   typedef enum logic [1:0] {
      BRK_CLOSED = 2'd0,
      BRK_OPEN   = 2'd1,
      BRK_HALF   = 2'd2
   } brk_state_type;

   // config register indexes
   localparam logic [1:0] CSR_CIRCUITS = 2'd0;
   localparam logic [1:0] CSR_FAIL_LIM = 2'd1;
   localparam logic [1:0] CSR_SUCC_LIM = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT  = 2'd3;

   localparam logic [4:0]  CIRCUITS_RST = 5'd0;
   localparam logic [15:0] FAIL_LIM_RST = 16'd5;
   localparam logic [15:0] SUCC_LIM_RST = 16'd2;
   localparam logic [31:0] TIMEOUT_RST  = 32'd1000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  breaker_index;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        allowed;
      logic [1:0]  breaker_state_out;
      logic        found;
      logic [31:0] trip_total;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  circuits_in_use;
      logic [15:0] failure_limit;
      logic [15:0] success_limit;
      logic [31:0] open_timeout_ms;
   } cfg_type;

   // one table entry
   typedef struct packed {
      brk_state_type state;
      logic [15:0]   fail_run;
      logic [15:0]   success_run;
      logic [31:0]   changed_at_ms;
   } entry_type;

   localparam entry_type ENTRY_RST = '{
      state:         BRK_CLOSED,
      fail_run:      16'd0,
      success_run:   16'd0,
      changed_at_ms: 32'd0
   };

   // outcome of one item against its entry
   typedef struct packed {
      logic          allowed;
      logic          trip_inc;
      brk_state_type state;
      entry_type     entry;
   } upd_type;

endpackage

`default_nettype wire

// ===== src/circuit_breaker_table_unit.sv =====
// ----------------------------------------------------------------------------
// circuit_breaker_table_unit
// table of closed / open / half-open circuit breakers, one entry per index
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------
//   req_     | in        | req_valid/req_stall | req_item (mode, index, now)
//   rsp_     | out       | rsp_valid/rsp_stall | rsp_item (allowed, state, ...)
//   csr_     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// - one item per cycle while the result is not stalled; the accepting edge
//   loads stage one and starts the entry read, and the result register is
//   loaded when stage one advances
// - the entry read-modify-write is the loop: a write and the next read of the
//   same entry share an edge, and the memory forwards the written entry
// - reset clears the valid bits at once, so there is no clearing pass; an
//   entry never written reads as closed with zero runs
// - a stalled result holds stage one, and a held stage one stalls the input
// - config writes are always taken (csr_ready tied high)
// ----------------------------------------------------------------------------
`default_nettype none

module circuit_breaker_table_unit #(
   parameter int NUM_BREAKERS = cbt_pkg::NUM_BREAKERS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // item input
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cbt_pkg::req_type req_item,
   // result output
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cbt_pkg::rsp_type      rsp_item,
   // config writes
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);
   import cbt_pkg::*;

   localparam int         ADDR_W    = (NUM_BREAKERS > 1) ? $clog2(NUM_BREAKERS) : 1;
   localparam logic [8:0] NUM_LIMIT = 9'(NUM_BREAKERS);

   // config registers
   cfg_type cfg_ff;

   // stage one: item waiting on its entry read
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_item_ff;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type rsp_item_in;

   // saturating trip counter
   logic [31:0] trip_ff;
   logic [31:0] trip_in;

   logic              accept;
   logic              out_free;
   logic              s1_adv;
   logic              s1_found;
   logic              wr_en;
   logic [ADDR_W-1:0] s1_addr;
   entry_type         cur_entry;
   upd_type           upd;

   // handshake
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_adv      = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   // index must be below both the configured count and the table depth
   assign s1_found = ({1'b0, s1_item_ff.breaker_index} < cfg_ff.circuits_in_use)
                  && ({5'd0, s1_item_ff.breaker_index} < NUM_LIMIT);
   assign s1_addr  = ADDR_W'(s1_item_ff.breaker_index);
   assign wr_en    = s1_adv && s1_found;

   cbt_entry_mem #(
      .NUM_BREAKERS (NUM_BREAKERS),
      .ADDR_W       (ADDR_W)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (ADDR_W'(req_item.breaker_index)),
      .wr_en    (wr_en),
      .wr_addr  (s1_addr),
      .wr_entry (upd.entry),
      .rd_entry (cur_entry)
   );

   cbt_update u_update (
      .entry (cur_entry),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .upd   (upd)
   );

   // trips only count on a found item that actually leaves stage one
   always_comb begin
      trip_in = trip_ff;
      if (wr_en && upd.trip_inc && (trip_ff != 32'hFFFF_FFFF)) begin
         trip_in = trip_ff + 32'd1;
      end
   end

   always_comb begin
      if (s1_found) begin
         rsp_item_in.allowed           = upd.allowed;
         rsp_item_in.breaker_state_out = upd.state;
         rsp_item_in.found             = 1'b1;
      end else begin
         // unused index: answers as a closed breaker, nothing changes
         rsp_item_in.allowed           = 1'b1;
         rsp_item_in.breaker_state_out = BRK_CLOSED;
         rsp_item_in.found             = 1'b0;
      end
      rsp_item_in.trip_total = trip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         trip_ff      <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         trip_ff      <= trip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (s1_adv) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // config register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.circuits_in_use <= CIRCUITS_RST;
         cfg_ff.failure_limit   <= FAIL_LIM_RST;
         cfg_ff.success_limit   <= SUCC_LIM_RST;
         cfg_ff.open_timeout_ms <= TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CIRCUITS: cfg_ff.circuits_in_use <= csr_wdata[4:0];
            CSR_FAIL_LIM: cfg_ff.failure_limit   <= csr_wdata[15:0];
            CSR_SUCC_LIM: cfg_ff.success_limit   <= csr_wdata[15:0];
            CSR_TIMEOUT:  cfg_ff.open_timeout_ms <= csr_wdata;
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // an unused index always answers allowed and closed
   a_unused_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.found |->
         rsp_item_ff.allowed && (rsp_item_ff.breaker_state_out == BRK_CLOSED))
      else $error("unused index answered other than allowed/closed");

   // a breaker that is open after the step never lets a call through
   a_open_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.found && rsp_item_ff.allowed |->
         (rsp_item_ff.breaker_state_out != BRK_OPEN))
      else $error("open breaker reported allowed");

   // trip count only grows
   a_trip_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (trip_ff >= $past(trip_ff)))
      else $error("trip counter went down");

   // an item leaving stage one always lands in the result register
   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("stage one advanced without a result");

endmodule

`default_nettype wire

// ===== src/cbt_entry_mem.sv =====
// ----------------------------------------------------------------------------
// cbt_entry_mem
// breaker entry memory: one write and one registered read per cycle, per-entry
// valid bits for the reset value, and forwarding of a same-cycle write
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_entry_mem #(
   parameter int NUM_BREAKERS = cbt_pkg::NUM_BREAKERS_DEF,
   parameter int ADDR_W       = (NUM_BREAKERS > 1) ? $clog2(NUM_BREAKERS) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire cbt_pkg::entry_type wr_entry,
   output cbt_pkg::entry_type      rd_entry
);
   import cbt_pkg::*;

   entry_type               mem_ram [NUM_BREAKERS];
   entry_type               rd_data_ff;
   logic                    rd_vld_ff;
   logic [NUM_BREAKERS-1:0] vld_ff;
   logic                    fwd_hit_ff;
   entry_type               fwd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff   <= mem_ram[rd_addr];
         fwd_entry_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff  <= vld_ff[rd_addr];
            // write landing on the same edge as the read
            fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         rd_entry = fwd_entry_ff;
      end else if (rd_vld_ff) begin
         rd_entry = rd_data_ff;
      end else begin
         rd_entry = ENTRY_RST;
      end
   end

endmodule

`default_nettype wire

// ===== src/cbt_update.sv =====
// ----------------------------------------------------------------------------
// cbt_update
// next entry, allowed flag and trip event for one item
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_update (
   input  wire cbt_pkg::entry_type entry,
   input  wire cbt_pkg::req_type   item,
   input  wire cbt_pkg::cfg_type   cfg,
   output cbt_pkg::upd_type        upd
);
   import cbt_pkg::*;

   logic [31:0] elapsed;
   logic [15:0] fail_inc;
   logic [15:0] succ_inc;
   entry_type   nxt;
   logic        allowed;
   logic        trip_inc;

   assign elapsed  = item.now_ms - entry.changed_at_ms;
   assign fail_inc = (entry.fail_run == 16'hFFFF) ? entry.fail_run : entry.fail_run + 16'd1;
   assign succ_inc = (entry.success_run == 16'hFFFF) ? entry.success_run
                                                     : entry.success_run + 16'd1;

   always_comb begin
      nxt      = entry;
      allowed  = 1'b0;
      trip_inc = 1'b0;
      unique case (op_type'(item.mode))
         OP_CHECK: begin
            if (entry.state == BRK_OPEN) begin
               if (elapsed > cfg.open_timeout_ms) begin
                  nxt.state         = BRK_HALF;
                  nxt.changed_at_ms = item.now_ms;
                  nxt.success_run   = 16'd0;
                  allowed           = 1'b1;
               end
            end else begin
               allowed = 1'b1;
            end
         end
         OP_SUCCESS: begin
            nxt.success_run = succ_inc;
            nxt.fail_run    = 16'd0;
            if (entry.state == BRK_HALF && succ_inc >= cfg.success_limit) begin
               nxt.state         = BRK_CLOSED;
               nxt.changed_at_ms = item.now_ms;
            end
         end
         OP_FAILURE: begin
            nxt.fail_run = fail_inc;
            if (entry.state == BRK_CLOSED) begin
               if (fail_inc >= cfg.failure_limit) begin
                  nxt.state         = BRK_OPEN;
                  nxt.changed_at_ms = item.now_ms;
                  trip_inc          = 1'b1;
               end
            end else if (entry.state == BRK_HALF) begin
               nxt.state         = BRK_OPEN;
               nxt.changed_at_ms = item.now_ms;
            end
         end
         OP_RESET: begin
            nxt.state         = BRK_CLOSED;
            nxt.fail_run      = 16'd0;
            nxt.success_run   = 16'd0;
            nxt.changed_at_ms = item.now_ms;
         end
         default: begin
            nxt = entry;
         end
      endcase
   end

   assign upd.allowed  = allowed;
   assign upd.trip_inc = trip_inc;
   assign upd.state    = nxt.state;
   assign upd.entry    = nxt;

endmodule

`default_nettype wire

// ===== bench/tb_circuit_breaker_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circuit_breaker_table_unit
// self-checking regression for the circuit breaker table unit
// ----------------------------------------------------------------------------
// drives check / success / failure / reset items into the table, predicts
// every result with a behavioral copy of the breaker table and compares each
// result field by field in arrival order; runs a directed sequence, register
// extremes, random traffic under several idle and stall mixes, and a long
// receiver hold-off that backs up the input
// ----------------------------------------------------------------------------

module tb_circuit_breaker_table_unit;

   import cbt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 250;
   localparam int REPORT_MAX  = 10;

   // clock and reset
   logic clock = 1'b0;
   logic reset;

   // item channel
   logic    req_valid;
   logic    req_stall;
   req_type req_item;

   // result channel
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   // register write channel
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   // idle mix, set by the running test
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;

   // long hold-off requests: the test bumps the ask count, the receiver
   // process serves it
   int hold_asked  = 0;
   int hold_served = 0;

   // shadow copy of the table and its registers
   brk_state_type shadow_state [16];
   logic [15:0]   shadow_fails [16];
   logic [15:0]   shadow_succ  [16];
   logic [31:0]   shadow_stamp [16];
   logic [31:0]   shadow_trips;
   cfg_type       shadow_cfg;

   // results still owed by the block, oldest first
   rsp_type expected_outcomes [$];

   int          fault_count = 0;
   int          cycle_count = 0;
   logic [31:0] sim_ms;

   circuit_breaker_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // breaker prediction
   // ------------------------------------------------------------------------

   function automatic void clear_breakers();
      for (int i = 0; i < 16; i++) begin
         shadow_state[i] = BRK_CLOSED;
         shadow_fails[i] = '0;
         shadow_succ[i]  = '0;
         shadow_stamp[i] = '0;
      end
      shadow_trips = '0;
      shadow_cfg.circuits_in_use = CIRCUITS_RST;
      shadow_cfg.failure_limit   = FAIL_LIM_RST;
      shadow_cfg.success_limit   = SUCC_LIM_RST;
      shadow_cfg.open_timeout_ms = TIMEOUT_RST;
   endfunction

   // applies one item to the shadow table and returns the result it owes
   function automatic rsp_type predict_breaker(req_type it);
      rsp_type       r;
      brk_state_type st;
      logic [3:0]    idx;
      logic [31:0]   elapsed;
      idx = it.breaker_index;
      r.allowed    = 1'b0;
      r.found      = 1'b1;
      // index outside the entries in use: nothing changes, answers closed
      if (5'(idx) >= shadow_cfg.circuits_in_use) begin
         r.allowed           = 1'b1;
         r.breaker_state_out = BRK_CLOSED;
         r.found             = 1'b0;
         r.trip_total        = shadow_trips;
         return r;
      end
      st = shadow_state[idx];
      case (it.mode)
         OP_CHECK: begin
            if (st == BRK_OPEN) begin
               // wrap-safe elapsed time, strictly past the timeout
               elapsed = it.now_ms - shadow_stamp[idx];
               if (elapsed > shadow_cfg.open_timeout_ms) begin
                  st                = BRK_HALF;
                  shadow_stamp[idx] = it.now_ms;
                  shadow_succ[idx]  = '0;
                  r.allowed         = 1'b1;
               end
            end else begin
               r.allowed = 1'b1;
            end
         end
         OP_SUCCESS: begin
            if (shadow_succ[idx] != 16'hFFFF) shadow_succ[idx] = shadow_succ[idx] + 1'b1;
            shadow_fails[idx] = '0;
            if (st == BRK_HALF && shadow_succ[idx] >= shadow_cfg.success_limit) begin
               st                = BRK_CLOSED;
               shadow_stamp[idx] = it.now_ms;
            end
         end
         OP_FAILURE: begin
            if (shadow_fails[idx] != 16'hFFFF) shadow_fails[idx] = shadow_fails[idx] + 1'b1;
            if (st == BRK_CLOSED) begin
               if (shadow_fails[idx] >= shadow_cfg.failure_limit) begin
                  st                = BRK_OPEN;
                  shadow_stamp[idx] = it.now_ms;
                  if (shadow_trips != 32'hFFFF_FFFF) shadow_trips = shadow_trips + 1'b1;
               end
            end else if (st == BRK_HALF) begin
               // any failure in half-open reopens, no trip counted
               st                = BRK_OPEN;
               shadow_stamp[idx] = it.now_ms;
            end
         end
         default: begin
            st                = BRK_CLOSED;
            shadow_fails[idx] = '0;
            shadow_succ[idx]  = '0;
            shadow_stamp[idx] = it.now_ms;
         end
      endcase
      shadow_state[idx]   = st;
      r.breaker_state_out = st;
      r.trip_total        = shadow_trips;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_type make_request(op_type op, int idx, logic [31:0] now);
      req_type it;
      it.mode          = op;
      it.breaker_index = 4'(idx);
      it.now_ms        = now;
      return it;
   endfunction

   // mostly in-use breakers and slowly advancing time, so breakers cycle
   // through open, half-open and closed; the rest is indexes drawn from the
   // whole range, and time jumps
   function automatic req_type random_request();
      int     in_use;
      int     roll;
      int     idx;
      op_type op;
      in_use = int'(shadow_cfg.circuits_in_use);
      if (in_use > 0 && $urandom_range(99) < 88) idx = $urandom_range(in_use - 1);
      else idx = $urandom_range(15);
      roll = $urandom_range(99);
      if (roll < 34) op = OP_CHECK;
      else if (roll < 56) op = OP_SUCCESS;
      else if (roll < 92) op = OP_FAILURE;
      else op = OP_RESET;
      if ($urandom_range(99) < 4) sim_ms = $urandom();
      else sim_ms = sim_ms + $urandom_range(40);
      return make_request(op, idx, sim_ms);
   endfunction

   // offers one item and books its expected result once it is taken
   task automatic offer_request(input req_type it);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      expected_outcomes.push_back(predict_breaker(it));
   endtask

   // stop offering and wait for every owed result
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CIRCUITS: shadow_cfg.circuits_in_use = value[4:0];
         CSR_FAIL_LIM: shadow_cfg.failure_limit   = value[15:0];
         CSR_SUCC_LIM: shadow_cfg.success_limit   = value[15:0];
         default:      shadow_cfg.open_timeout_ms = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // register writes only with the block drained
   task automatic configure(input logic [31:0] circuits, input logic [31:0] fail_lim,
                            input logic [31:0] succ_lim, input logic [31:0] timeout);
      wait_idle();
      write_csr(CSR_CIRCUITS, circuits);
      write_csr(CSR_FAIL_LIM, fail_lim);
      write_csr(CSR_SUCC_LIM, succ_lim);
      write_csr(CSR_TIMEOUT, timeout);
   endtask

   task automatic run_phase(input logic [31:0] circuits, input logic [31:0] fail_lim,
                            input logic [31:0] succ_lim, input logic [31:0] timeout,
                            input int send_pct, input int stall_pct, input int count);
      configure(circuits, fail_lim, succ_lim, timeout);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) offer_request(random_request());
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_directed();
      // reset defaults have no breaker in use
      offer_request(make_request(OP_CHECK, 0, 32'd0));
      configure(32'd4, 32'd2, 32'd2, 32'd100);
      offer_request(make_request(OP_CHECK,   0, 32'd0));
      offer_request(make_request(OP_FAILURE, 0, 32'd10));
      // second failure trips the breaker
      offer_request(make_request(OP_FAILURE, 0, 32'd20));
      // failure while open keeps counting, stays open
      offer_request(make_request(OP_FAILURE, 0, 32'd30));
      // elapsed equal to the timeout is not enough
      offer_request(make_request(OP_CHECK,   0, 32'd120));
      offer_request(make_request(OP_CHECK,   0, 32'd121));
      offer_request(make_request(OP_SUCCESS, 0, 32'd130));
      // failure in half-open reopens
      offer_request(make_request(OP_FAILURE, 0, 32'd140));
      offer_request(make_request(OP_CHECK,   0, 32'd241));
      offer_request(make_request(OP_SUCCESS, 0, 32'd250));
      offer_request(make_request(OP_SUCCESS, 0, 32'd260));
      // success on a closed breaker changes nothing visible
      offer_request(make_request(OP_SUCCESS, 0, 32'd270));
      // open just before the time wraps, then check across the wrap
      offer_request(make_request(OP_FAILURE, 3, 32'hFFFF_FFF0));
      offer_request(make_request(OP_FAILURE, 3, 32'hFFFF_FFF8));
      offer_request(make_request(OP_CHECK,   3, 32'h0000_0050));
      offer_request(make_request(OP_CHECK,   3, 32'h0000_0070));
      offer_request(make_request(OP_RESET,   3, 32'hFFFF_FFFF));
      // first index past the ones in use, and the top index
      offer_request(make_request(OP_CHECK,   4, 32'd5));
      offer_request(make_request(OP_FAILURE, 15, 32'd6));
      offer_request(make_request(OP_RESET,   1, 32'd0));
      offer_request(make_request(OP_CHECK,   2, 32'h8000_0000));
      // zero limits and zero timeout
      configure(32'd16, 32'd0, 32'd0, 32'd0);
      offer_request(make_request(OP_FAILURE, 15, 32'd500));
      offer_request(make_request(OP_CHECK,   15, 32'd500));
      offer_request(make_request(OP_CHECK,   15, 32'd501));
      offer_request(make_request(OP_SUCCESS, 15, 32'd502));
   endtask

   task automatic test_limits();
      // largest limits and timeout, single breaker
      run_phase(32'd1, 32'd65535, 32'd65535, 32'hFFFF_FFFF, 0, 0, 30);
      // no breaker in use at all
      run_phase(32'd0, 32'd3, 32'd1, 32'd20, 0, 0, 12);
   endtask

   task automatic test_idle_free();
      run_phase(32'd16, 32'd3, 32'd2, 32'd30, 0, 0, 270);
   endtask

   task automatic test_sender_gaps();
      run_phase(32'd5, 32'd1, 32'd1, 32'd10, 58, 0, 270);
   endtask

   task automatic test_receiver_stalls();
      run_phase(32'd11, 32'd4, 32'd3, 32'd50, 0, 58, 270);
   endtask

   task automatic test_both_idle();
      run_phase(32'd8, 32'd2, 32'd2, 32'd0, 29, 29, 270);
   endtask

   // receiver holds off while items keep coming, so the input backs up
   task automatic test_backpressure();
      configure(32'd16, 32'd2, 32'd1, 32'd25);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_asked = hold_asked + 1;
      repeat (40) offer_request(random_request());
   endtask

   // ------------------------------------------------------------------------
   // receiver: random stalls, or one long hold-off when asked
   // ------------------------------------------------------------------------

   initial begin
      int held;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // result checking, oldest expectation first
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("unexpected result at %0t: allowed %0b state %0d found %0b trips %0d",
                        $time, rsp_item.allowed, rsp_item.breaker_state_out,
                        rsp_item.found, rsp_item.trip_total);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_item.allowed !== want.allowed ||
                rsp_item.breaker_state_out !== want.breaker_state_out ||
                rsp_item.found !== want.found ||
                rsp_item.trip_total !== want.trip_total) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display({"mismatch at %0t (expected/actual): allowed %0b/%0b ",
                            "state %0d/%0d found %0b/%0b trips %0d/%0d"},
                           $time, want.allowed, rsp_item.allowed,
                           want.breaker_state_out, rsp_item.breaker_state_out,
                           want.found, rsp_item.found,
                           want.trip_total, rsp_item.trip_total);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("circuit_breaker_table_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CIRCUITS;
      csr_wdata = '0;
      sim_ms    = $urandom();
      clear_breakers();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_limits();
      test_idle_free();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_backpressure();

      // drain, then let the pipeline run on to show any stray result
      wait_idle();
      repeat (6) @(posedge clock);
      if (fault_count == 0 && expected_outcomes.size() == 0) begin
         $display("circuit_breaker_table_unit regression: pass");
      end else begin
         $display("circuit_breaker_table_unit regression: fail");
      end
      $finish;
   end

endmodule
